// ----- rtl/core/adaptive_gain_fade_smoother_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the adaptive gain fade smoother
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_GAIN_FADE_SMOOTHER_ASSERT_SVH
`define ADAPTIVE_GAIN_FADE_SMOOTHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AGFS_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AGFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/agfs_pkg.sv -----
// ----------------------------------------------------------------------------
// agfs_pkg
// Types and fixed constants of the adaptive gain fade smoother.
// ----------------------------------------------------------------------------
package agfs_pkg;

	localparam int MGT_W  = 23;
	localparam int FT_W   = 17;
	localparam int RATE_W = 18;
	localparam int IDX_W  = 2;
	localparam int DATA_W = 23;

	localparam logic [IDX_W-1:0] REG_MAIN_GAIN = 2'd0;
	localparam logic [IDX_W-1:0] REG_FADE      = 2'd1;
	localparam logic [IDX_W-1:0] REG_RATE      = 2'd2;

	localparam logic [MGT_W-1:0]  MGT_RST  = 23'd65536;
	localparam logic [FT_W-1:0]   FT_RST   = 17'd65536;
	localparam logic [RATE_W-1:0] RATE_RST = 18'd44100;

	localparam int GAIN_W  = 32;
	localparam int FGAIN_W = 25;
	localparam int SLOW_W  = 28;
	localparam int FS_W    = 35;
	localparam int NUM_W   = 64;
	localparam int DEN_W   = 36;
	localparam int QUO_W   = 35;
	localparam int QCNT_W  = 6;
	localparam int PROD_W  = 64;
	localparam int GQ_W    = 33;
	localparam int MUL_A_W = 35;
	localparam int MUL_B_W = 33;
	localparam int Q_SHIFT = 24;
	localparam int SCL_W   = PROD_W - Q_SHIFT;
	localparam int DECAY_SHIFT = 42;

	localparam logic [SLOW_W-1:0] SLOW_MIN   = 28'd22937600;
	localparam logic [SLOW_W-1:0] SLOW_MAX   = 28'd163840000;
	localparam logic [SLOW_W-1:0] SLOW_STEP  = 28'd655;
	localparam logic [SLOW_W-1:0] DECAY_BIAS = 28'd9999;
	localparam logic [MUL_B_W-1:0] DECAY_RECIP = 33'd439804652;
	localparam logic [FT_W-1:0]   FADE_FLOOR = 17'd177;
	localparam logic [7:0]        FADE_MUL   = 8'd250;
	localparam logic [DEN_W-1:0]  UNITY_DEN  = 36'd65536;
	localparam logic [PROD_W-1:0] ROUND_HALF = 64'h0000_0000_0080_0000;
	localparam logic [PROD_W-1:0] UNITY_PROD = 64'h0001_0000_0000_0000;

	localparam logic [QCNT_W-1:0] Q_FSLOW = 6'd35;
	localparam logic [QCNT_W-1:0] Q_MAIN  = 6'd32;
	localparam logic [QCNT_W-1:0] Q_FADE  = 6'd25;

	typedef struct packed {
		logic [MGT_W-1:0]  main_gain_target;
		logic [FT_W-1:0]   fade_target;
		logic [RATE_W-1:0] sample_rate_hz;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		logic [DEN_W-1:0]  den;
		logic [QCNT_W-1:0] qbits;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

endpackage

// ----- rtl/core/agfs_if.sv -----
// ----------------------------------------------------------------------------
// agfs_if
// Valid/ready stream channels for samples in and gained samples out.
// ----------------------------------------------------------------------------
interface agfs_in_if #(parameter int SAMPLE_WIDTH = 24) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;
	logic                           block_last;

	modport source (output valid, output sample_in, output block_last, input ready);
	modport sink (input valid, input sample_in, input block_last, output ready);
endinterface

interface agfs_out_if #(parameter int SAMPLE_WIDTH = 24) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

// ----- rtl/core/adaptive_gain_fade_smoother.sv -----
// ----------------------------------------------------------------------------
// adaptive_gain_fade_smoother
// Scales audio samples by a smoothed main gain times a smoothed fade gain.
// ----------------------------------------------------------------------------
// Channel     Dir  Payload                   Beat moves when
// sample_ch   in   sample_in, block_last     valid && ready
// result_ch   out  sample_out                valid && ready
// wr_*        in   wr_index, wr_data         wr_en
//
// A new sample is taken in only once the core is idle again; the shared
// divider yields one quotient bit per cycle for the fade slowness and
// both gain chases.
// Reset clears the gains, sets the slowness to 350 and restores the registers.
// A result waits in the output register while the next sample is taken in;
// the core stalls only if a second result finishes before the first is taken.
// ----------------------------------------------------------------------------
module adaptive_gain_fade_smoother #(
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	agfs_in_if.sink                     sample_ch,
	agfs_out_if.source                  result_ch,
	input  logic                        wr_en,
	input  logic [agfs_pkg::IDX_W-1:0]  wr_index,
	input  logic [agfs_pkg::DATA_W-1:0] wr_data
);

	agfs_pkg::cfg_t           cfg;
	agfs_pkg::div_req_t       div_req;
	agfs_pkg::div_rsp_t       div_rsp;
	logic                     res_space;
	logic                     res_fire;
	logic signed [SAMPLE_WIDTH-1:0] res_sample;
	logic                     out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] out_sample_q;

	agfs_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	agfs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	agfs_core #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.sample_ch  (sample_ch),
		.res_space  (res_space),
		.res_fire   (res_fire),
		.res_sample (res_sample),
		.div_req    (div_req),
		.div_rsp    (div_rsp)
	);

	assign res_space = !out_valid_q || result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_fire) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			out_sample_q <= res_sample;
		end
	end

	assign result_ch.valid      = out_valid_q;
	assign result_ch.sample_out = out_sample_q;

endmodule

// ----- rtl/core/agfs_regs.sv -----
// ----------------------------------------------------------------------------
// agfs_regs
// Configuration registers: main gain target, fade target and sample rate.
// ----------------------------------------------------------------------------
module agfs_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [agfs_pkg::IDX_W-1:0]   wr_index,
	input  logic [agfs_pkg::DATA_W-1:0]  wr_data,
	output agfs_pkg::cfg_t               cfg
);

	agfs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.main_gain_target <= agfs_pkg::MGT_RST;
			cfg_q.fade_target      <= agfs_pkg::FT_RST;
			cfg_q.sample_rate_hz   <= agfs_pkg::RATE_RST;
		end else if (wr_en) begin
			case (wr_index)
				agfs_pkg::REG_MAIN_GAIN: begin
					cfg_q.main_gain_target <= wr_data[agfs_pkg::MGT_W-1:0];
				end
				agfs_pkg::REG_FADE: begin
					cfg_q.fade_target <= wr_data[agfs_pkg::FT_W-1:0];
				end
				agfs_pkg::REG_RATE: begin
					cfg_q.sample_rate_hz <= wr_data[agfs_pkg::RATE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/agfs_div.sv -----
// ----------------------------------------------------------------------------
// agfs_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "adaptive_gain_fade_smoother_assert.svh"

module agfs_div (
	input  logic                clk,
	input  logic                arst_n,
	input  agfs_pkg::div_req_t  req,
	output agfs_pkg::div_rsp_t  rsp
);

	localparam int NUM_W  = agfs_pkg::NUM_W;
	localparam int DEN_W  = agfs_pkg::DEN_W;
	localparam int QUO_W  = agfs_pkg::QUO_W;
	localparam int QCNT_W = agfs_pkg::QCNT_W;

	logic              busy_q;
	logic              done_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [NUM_W-1:0]  low_q;
	logic [QUO_W-1:0]  quo_q;

	logic [DEN_W:0]    part;
	logic [DEN_W+1:0]  diff;
	logic              take;
	logic [NUM_W-1:0]  hi_load;
	logic [QCNT_W:0]   lsh;
	logic              last_step;

	assign part      = {rem_q, low_q[NUM_W-1]};
	assign diff      = {1'b0, part} - {2'b00, den_q};
	assign take      = !diff[DEN_W+1];
	assign hi_load   = req.num >> req.qbits;
	assign lsh       = (QCNT_W+1)'(NUM_W) - {1'b0, req.qbits};
	assign last_step = busy_q && (cnt_q == QCNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.qbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - QCNT_W'(1);
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= hi_load[DEN_W-1:0];
			den_q <= req.den;
			low_q <= req.num << lsh;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? diff[DEN_W-1:0] : part[DEN_W-1:0];
			low_q <= {low_q[NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], take};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	`AGFS_ASSERT(a_div_start_idle, req.start, !busy_q, "divider started while busy")
	`AGFS_ASSERT(a_div_rem_bound, busy_q, rem_q < den_q, "partial remainder not below divisor")
	`AGFS_ASSERT_NEXT(a_div_finish, last_step && !req.start, done_q && !busy_q, "divider missed its finish")

endmodule

// ----- rtl/core/agfs_core.sv -----
// ----------------------------------------------------------------------------
// agfs_core
// Sequencer and datapath: slowness update, gain chasing and sample scaling.
// ----------------------------------------------------------------------------
`include "adaptive_gain_fade_smoother_assert.svh"

module agfs_core #(
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  agfs_pkg::cfg_t                 cfg,
	agfs_in_if.sink                        sample_ch,
	input  logic                           res_space,
	output logic                           res_fire,
	output logic signed [SAMPLE_WIDTH-1:0] res_sample,
	output agfs_pkg::div_req_t             div_req,
	input  agfs_pkg::div_rsp_t             div_rsp
);

	localparam int GAIN_W  = agfs_pkg::GAIN_W;
	localparam int FGAIN_W = agfs_pkg::FGAIN_W;
	localparam int SLOW_W  = agfs_pkg::SLOW_W;
	localparam int FS_W    = agfs_pkg::FS_W;
	localparam int NUM_W   = agfs_pkg::NUM_W;
	localparam int DEN_W   = agfs_pkg::DEN_W;
	localparam int PROD_W  = agfs_pkg::PROD_W;
	localparam int GQ_W    = agfs_pkg::GQ_W;
	localparam int MUL_A_W = agfs_pkg::MUL_A_W;
	localparam int MUL_B_W = agfs_pkg::MUL_B_W;
	localparam int SCL_W   = agfs_pkg::SCL_W;
	localparam int Q_SHIFT = agfs_pkg::Q_SHIFT;
	localparam logic [SLOW_W-1:0] SMIN = agfs_pkg::SLOW_MIN;
	localparam logic [SLOW_W-1:0] SMAX = agfs_pkg::SLOW_MAX;
	localparam logic [SCL_W-1:0] HALF  = SCL_W'(1) << (SAMPLE_WIDTH - 1);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_START   = 4'd1;
	localparam logic [3:0] S_D_MUL   = 4'd2;
	localparam logic [3:0] S_D_UPD   = 4'd3;
	localparam logic [3:0] S_F_GO    = 4'd4;
	localparam logic [3:0] S_F_WAIT  = 4'd5;
	localparam logic [3:0] S_MUL_M   = 4'd6;
	localparam logic [3:0] S_MC_GO   = 4'd7;
	localparam logic [3:0] S_MC_WAIT = 4'd8;
	localparam logic [3:0] S_MUL_F   = 4'd9;
	localparam logic [3:0] S_FC_GO   = 4'd10;
	localparam logic [3:0] S_FC_WAIT = 4'd11;
	localparam logic [3:0] S_MUL_G   = 4'd12;
	localparam logic [3:0] S_ROUND   = 4'd13;
	localparam logic [3:0] S_MUL_S   = 4'd14;
	localparam logic [3:0] S_FIN     = 4'd15;

	logic [3:0]                state_q;
	logic                      started_q;
	logic                      blk_start_q;
	logic [SLOW_W-1:0]         slow_q;
	logic [agfs_pkg::MGT_W-1:0] last_tgt_q;
	logic [GAIN_W-1:0]         main_g_q;
	logic [FGAIN_W-1:0]        fade_g_q;

	logic [SAMPLE_WIDTH-1:0]   sample_q;
	logic                      last_q;
	logic [FS_W-1:0]           fs_q;
	logic [PROD_W-1:0]         prod_q;
	logic [GQ_W-1:0]           gq_q;
	logic                      unity_q;

	logic                      accept;
	logic                      chg;
	logic [SLOW_W:0]           dbl;
	logic [SLOW_W-1:0]         capped;
	logic [agfs_pkg::MGT_W-1:0] tgt_new;
	logic [SLOW_W-1:0]         decay;
	logic [SLOW_W-1:0]         slow_next;
	logic [agfs_pkg::FT_W-1:0] ftc;
	logic [DEN_W-1:0]          den_m;
	logic [DEN_W-1:0]          den_f;
	logic [MUL_A_W-1:0]        mul_a;
	logic [MUL_B_W-1:0]        mul_b;
	logic [MUL_A_W+MUL_B_W-1:0] mul_p;
	logic                      neg;
	logic [SAMPLE_WIDTH-1:0]   mag;
	logic [PROD_W-1:0]         rnd;
	logic [SCL_W-1:0]          scaled;
	logic [SCL_W-1:0]          pos_mag;
	logic [SCL_W-1:0]          neg_mag;
	logic [SAMPLE_WIDTH-1:0]   res_u;

	assign sample_ch.ready = (state_q == S_IDLE);
	assign accept          = sample_ch.valid && (state_q == S_IDLE);

	assign chg     = (cfg.main_gain_target != last_tgt_q);
	assign dbl     = chg ? {slow_q, 1'b0} : {1'b0, slow_q};
	assign capped  = (dbl > {1'b0, SMAX}) ? SMAX : dbl[SLOW_W-1:0];
	assign tgt_new = chg ? cfg.main_gain_target : last_tgt_q;

	// The reciprocal product gives the quotient by 10000 rounded up, so the
	// difference is the slowness times 0.9999, truncated.
	assign decay     = slow_q - SLOW_W'(prod_q[PROD_W-1:agfs_pkg::DECAY_SHIFT]);
	assign slow_next = (decay < SMIN + agfs_pkg::SLOW_STEP) ? SMIN
		: decay - agfs_pkg::SLOW_STEP;

	assign ftc   = (cfg.fade_target < agfs_pkg::FADE_FLOOR) ? agfs_pkg::FADE_FLOOR
		: cfg.fade_target;
	assign den_m = DEN_W'(slow_q) + agfs_pkg::UNITY_DEN;
	assign den_f = DEN_W'(fs_q) + agfs_pkg::UNITY_DEN;

	always_comb begin
		div_req = '0;
		case (state_q)
			S_F_GO: begin
				div_req.start = 1'b1;
				div_req.num   = NUM_W'({cfg.sample_rate_hz, 32'h0});
				div_req.den   = DEN_W'(ftc) * DEN_W'(agfs_pkg::FADE_MUL);
				div_req.qbits = agfs_pkg::Q_FSLOW;
			end
			S_MC_GO: begin
				div_req.start = 1'b1;
				div_req.num   = prod_q + NUM_W'({last_tgt_q, 24'h0}) + NUM_W'(den_m >> 1);
				div_req.den   = den_m;
				div_req.qbits = agfs_pkg::Q_MAIN;
			end
			S_FC_GO: begin
				div_req.start = 1'b1;
				div_req.num   = prod_q + NUM_W'({cfg.fade_target, 24'h0})
					+ NUM_W'(den_f >> 1);
				div_req.den   = den_f;
				div_req.qbits = agfs_pkg::Q_FADE;
			end
			default: begin
			end
		endcase
	end

	assign neg = sample_q[SAMPLE_WIDTH-1];
	assign mag = neg ? (~sample_q + 1'b1) : sample_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_D_MUL: begin
				mul_a = MUL_A_W'(slow_q) + MUL_A_W'(agfs_pkg::DECAY_BIAS);
				mul_b = agfs_pkg::DECAY_RECIP;
			end
			S_MUL_M: begin
				mul_a = MUL_A_W'(main_g_q);
				mul_b = MUL_B_W'(slow_q);
			end
			S_MUL_F: begin
				mul_a = fs_q;
				mul_b = MUL_B_W'(fade_g_q);
			end
			S_MUL_G: begin
				mul_a = MUL_A_W'(main_g_q);
				mul_b = MUL_B_W'(fade_g_q);
			end
			S_MUL_S: begin
				mul_a = MUL_A_W'(mag);
				mul_b = gq_q;
			end
			default: begin
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign rnd     = prod_q + agfs_pkg::ROUND_HALF;
	assign scaled  = rnd[Q_SHIFT +: SCL_W];
	assign pos_mag = (scaled > HALF - SCL_W'(1)) ? HALF - SCL_W'(1) : scaled;
	assign neg_mag = (scaled > HALF) ? HALF : scaled;
	assign res_u   = unity_q ? sample_q
		: (neg ? (~neg_mag[SAMPLE_WIDTH-1:0] + 1'b1) : pos_mag[SAMPLE_WIDTH-1:0]);

	assign res_fire   = (state_q == S_FIN) && res_space;
	assign res_sample = signed'(res_u);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			started_q   <= 1'b0;
			blk_start_q <= 1'b1;
			slow_q      <= SMIN;
			last_tgt_q  <= '0;
			main_g_q    <= '0;
			fade_g_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					if (blk_start_q) begin
						slow_q     <= capped;
						last_tgt_q <= tgt_new;
						if (!started_q) begin
							main_g_q  <= GAIN_W'({tgt_new, 8'h00});
							fade_g_q  <= {cfg.fade_target, 8'h00};
							started_q <= 1'b1;
						end
					end
					state_q <= S_D_MUL;
				end
				S_D_MUL: begin
					state_q <= S_D_UPD;
				end
				S_D_UPD: begin
					slow_q  <= slow_next;
					state_q <= S_F_GO;
				end
				S_F_GO: begin
					state_q <= S_F_WAIT;
				end
				S_F_WAIT: begin
					if (div_rsp.done) begin
						state_q <= S_MUL_M;
					end
				end
				S_MUL_M: begin
					state_q <= S_MC_GO;
				end
				S_MC_GO: begin
					state_q <= S_MC_WAIT;
				end
				S_MC_WAIT: begin
					if (div_rsp.done) begin
						main_g_q <= div_rsp.quo[GAIN_W-1:0];
						state_q  <= S_MUL_F;
					end
				end
				S_MUL_F: begin
					state_q <= S_FC_GO;
				end
				S_FC_GO: begin
					state_q <= S_FC_WAIT;
				end
				S_FC_WAIT: begin
					if (div_rsp.done) begin
						fade_g_q <= div_rsp.quo[FGAIN_W-1:0];
						state_q  <= S_MUL_G;
					end
				end
				S_MUL_G: begin
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					state_q <= S_MUL_S;
				end
				S_MUL_S: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (res_space) begin
						blk_start_q <= last_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample_ch.sample_in;
			last_q   <= sample_ch.block_last;
		end
		if ((state_q == S_F_WAIT) && div_rsp.done) begin
			fs_q <= div_rsp.quo[FS_W-1:0];
		end
		if ((state_q == S_D_MUL) || (state_q == S_MUL_M) || (state_q == S_MUL_F)
			|| (state_q == S_MUL_G) || (state_q == S_MUL_S)) begin
			prod_q <= mul_p[PROD_W-1:0];
		end
		if (state_q == S_ROUND) begin
			gq_q    <= rnd[Q_SHIFT +: GQ_W];
			unity_q <= (prod_q == agfs_pkg::UNITY_PROD);
		end
	end

	`AGFS_ASSERT(a_slow_range, 1'b1, (slow_q >= SMIN) && (slow_q <= SMAX), "slowness out of range")
	`AGFS_ASSERT(a_gains_started, state_q > S_START, started_q, "gains not loaded")
	`AGFS_ASSERT(a_main_gain_bound, 1'b1, !main_g_q[GAIN_W-1], "main gain reached its top bit")

endmodule

// ----- dv/adaptive_gain_fade_smoother_tb.sv -----
// ----------------------------------------------------------------------------
// adaptive_gain_fade_smoother_tb
// Streams audio samples through the gain smoother under random idling on both
// channels and checks every gained sample against a bit-exact fixed-point
// prediction of the smoothed main and fade gains. A directed opening covers
// pass-through at unity, sample extremes, saturation, fade above one, zero
// sample rate, the fade floor and an unused register index; random phases then
// retune the registers between runs of host blocks.
// ----------------------------------------------------------------------------
module adaptive_gain_fade_smoother_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW = 24;
	localparam int SAMPLE_TARGET = 700;
	localparam int STALL_LIMIT = 2000;
	localparam logic [agfs_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam bit [63:0] SLOWNESS_FLOOR = 64'd22937600;
	localparam bit [63:0] SLOWNESS_CAP = 64'd163840000;
	localparam bit [63:0] SLOWNESS_DECREMENT = 64'd655;
	localparam bit [63:0] FADE_TARGET_FLOOR = 64'd177;
	localparam bit [63:0] UNITY_Q48 = 64'h0001_0000_0000_0000;

	typedef logic signed [SW-1:0] sample_t;

	class gain_fade_scoreboard;
		bit [63:0] main_target;
		bit [63:0] fade_target;
		bit [63:0] rate_hz;
		bit [63:0] main_gain;
		bit [63:0] fade_gain;
		bit [63:0] slowness;
		bit [63:0] latched_main_target;
		bit        gains_loaded;
		bit        at_block_start;
		sample_t   expected_samples[$];
		int        mismatches;
		int        compared;

		function new();
			main_target = 64'(agfs_pkg::MGT_RST);
			fade_target = 64'(agfs_pkg::FT_RST);
			rate_hz = 64'(agfs_pkg::RATE_RST);
			main_gain = 0;
			fade_gain = 0;
			slowness = SLOWNESS_FLOOR;
			latched_main_target = 0;
			gains_loaded = 0;
			at_block_start = 1;
			mismatches = 0;
			compared = 0;
		endfunction

		function void set_register(logic [agfs_pkg::IDX_W-1:0] idx,
			logic [agfs_pkg::DATA_W-1:0] data);
			case (idx)
				agfs_pkg::REG_MAIN_GAIN: main_target = 64'(data[agfs_pkg::MGT_W-1:0]);
				agfs_pkg::REG_FADE: fade_target = 64'(data[agfs_pkg::FT_W-1:0]);
				agfs_pkg::REG_RATE: rate_hz = 64'(data[agfs_pkg::RATE_W-1:0]);
				default: ;
			endcase
		endfunction

		function bit [63:0] one_pole_step(bit [63:0] g, bit [63:0] s, bit [63:0] target);
			bit [63:0] den;
			bit [63:0] num;
			den = s + 64'd65536;
			num = g * s + (target << 16);
			return (num + den / 2) / den;
		endfunction

		function void note_sample(sample_t smp, logic blk_last);
			bit [63:0] raw;
			bit [63:0] mag;
			bit [63:0] ft;
			bit [63:0] fade_slowness;
			bit [63:0] decayed;
			bit [63:0] prod;
			bit [63:0] gain_q24;
			bit [63:0] scaled;
			bit [63:0] wide;
			bit        neg;
			sample_t   gained;
			raw = 64'(smp[SW-1:0]);
			neg = smp[SW-1];
			mag = neg ? ((64'd1 << SW) - raw) : raw;
			if (at_block_start) begin
				if (main_target != latched_main_target) begin
					slowness = slowness * 2;
					latched_main_target = main_target;
				end
				if (slowness > SLOWNESS_CAP)
					slowness = SLOWNESS_CAP;
				if (!gains_loaded) begin
					main_gain = latched_main_target << 8;
					fade_gain = fade_target << 8;
					gains_loaded = 1;
				end
			end
			ft = (fade_target < FADE_TARGET_FLOOR) ? FADE_TARGET_FLOOR : fade_target;
			fade_slowness = (rate_hz << 32) / (64'd250 * ft);
			decayed = slowness * 64'd9999 / 64'd10000;
			slowness = (decayed < SLOWNESS_FLOOR + SLOWNESS_DECREMENT) ? SLOWNESS_FLOOR
				: decayed - SLOWNESS_DECREMENT;
			main_gain = one_pole_step(main_gain, slowness, latched_main_target << 8)
				& 64'hFFFF_FFFF;
			fade_gain = one_pole_step(fade_gain, fade_slowness, fade_target << 8)
				& 64'hFFFF_FFFF;
			prod = main_gain * fade_gain;
			if (prod == UNITY_Q48) begin
				gained = smp;
			end else begin
				gain_q24 = (prod + (64'd1 << 23)) >> 24;
				scaled = (mag * gain_q24 + (64'd1 << 23)) >> 24;
				if (neg) begin
					if (scaled > (64'd1 << (SW - 1)))
						scaled = 64'd1 << (SW - 1);
					wide = (64'd1 << SW) - scaled;
				end else begin
					if (scaled > (64'd1 << (SW - 1)) - 1)
						scaled = (64'd1 << (SW - 1)) - 1;
					wide = scaled;
				end
				gained = wide[SW-1:0];
			end
			expected_samples.push_back(gained);
			at_block_start = blk_last;
		endfunction

		function void check_result(sample_t actual);
			sample_t want;
			if (expected_samples.size() == 0) begin
				$error("sample_out: no result expected, actual %0d", actual);
				mismatches++;
			end else begin
				want = expected_samples.pop_front();
				compared++;
				if (actual !== want) begin
					$error("sample_out mismatch: expected %0d, actual %0d", want, actual);
					mismatches++;
				end
			end
		endfunction

		function int pending();
			return expected_samples.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [agfs_pkg::IDX_W-1:0] wr_index;
	logic [agfs_pkg::DATA_W-1:0] wr_data;
	bit sender_calm;
	bit sink_calm;
	int samples_sent;
	int reg_writes;
	int phases;
	gain_fade_scoreboard sb;

	agfs_in_if #(.SAMPLE_WIDTH(SW)) sample_ch ();
	agfs_out_if #(.SAMPLE_WIDTH(SW)) result_ch ();

	adaptive_gain_fade_smoother #(.SAMPLE_WIDTH(SW)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_ch(sample_ch),
		.result_ch(result_ch),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic write_reg(input logic [agfs_pkg::IDX_W-1:0] idx,
		input logic [agfs_pkg::DATA_W-1:0] data);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		sb.set_register(idx, data);
		reg_writes++;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic push_sample(input sample_t smp, input logic blk_last);
		int gap;
		gap = sender_calm ? 0 : $urandom_range(0, 12);
		repeat (gap) begin
			@(negedge clk);
			sample_ch.valid <= 1'b0;
		end
		@(negedge clk);
		sample_ch.valid <= 1'b1;
		sample_ch.sample_in <= smp;
		sample_ch.block_last <= blk_last;
		do @(posedge clk); while (!sample_ch.ready);
		sb.note_sample(smp, blk_last);
		samples_sent++;
	endtask

	task automatic wait_for_results(input int settle);
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	function automatic sample_t random_sample();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0: return sample_t'(24'h7FFFFF);
			1: return sample_t'(24'h800000);
			2: return sample_t'($signed(r[10:0]));
			3: return r[0] ? sample_t'(1) : sample_t'(-1);
			default: return r[SW-1:0];
		endcase
	endfunction

	function automatic logic [agfs_pkg::DATA_W-1:0] pick_main_target();
		case ($urandom_range(0, 7))
			0: return 23'd0;
			1: return 23'd655;
			2: return 23'd65536;
			3: return 23'd6553600;
			4: return 23'h7FFFFF;
			5: return 23'($urandom_range(655, 6553600));
			default: return 23'($urandom_range(0, 23'h7FFFFF));
		endcase
	endfunction

	function automatic logic [agfs_pkg::DATA_W-1:0] pick_fade_target();
		case ($urandom_range(0, 7))
			0: return 23'd0;
			1: return 23'd176;
			2: return 23'd177;
			3: return 23'd65536;
			4: return 23'h1FFFF;
			5: return 23'($urandom_range(0, 17'h1FFFF));
			default: return 23'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic logic [agfs_pkg::DATA_W-1:0] pick_rate();
		case ($urandom_range(0, 7))
			0: return 23'd0;
			1: return 23'd8000;
			2: return 23'd44100;
			3: return 23'd192000;
			4: return 23'h3FFFF;
			5: return 23'($urandom_range(0, 18'h3FFFF));
			default: return 23'($urandom_range(8000, 192000));
		endcase
	endfunction

	task automatic retune();
		logic [2:0] which;
		which = 3'($urandom_range(1, 7));
		if (which[0])
			write_reg(agfs_pkg::REG_MAIN_GAIN, pick_main_target());
		if (which[1])
			write_reg(agfs_pkg::REG_FADE, pick_fade_target());
		if (which[2])
			write_reg(agfs_pkg::REG_RATE, pick_rate());
		if ($urandom_range(0, 9) == 0)
			write_reg(REG_UNUSED, 23'($urandom));
	endtask

	initial begin : result_sink
		int gap;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = sink_calm ? 0 : $urandom_range(0, 12);
			repeat (gap) begin
				@(negedge clk);
				result_ch.ready <= 1'b0;
			end
			@(negedge clk);
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			sb.check_result(result_ch.sample_out);
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (sample_ch.valid && sample_ch.ready)
				|| (result_ch.valid && result_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		int run_len;
		sb = new();
		samples_sent = 0;
		reg_writes = 0;
		phases = 0;
		sender_calm = 1'b0;
		sink_calm = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.sample_in = '0;
		sample_ch.block_last = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Both gains start at unity, so these samples pass through untouched.
		push_sample(sample_t'(24'h7FFFFF), 1'b0);
		push_sample(sample_t'(24'h800000), 1'b0);
		push_sample(sample_t'(0), 1'b1);
		push_sample(sample_t'(1), 1'b0);
		push_sample(sample_t'(-1), 1'b1);
		push_sample(sample_t'(12345), 1'b0);
		push_sample(sample_t'(-54321), 1'b1);
		wait_for_results(4);

		write_reg(agfs_pkg::REG_MAIN_GAIN, 23'h7FFFFF);
		write_reg(agfs_pkg::REG_FADE, 23'h1FFFF);
		write_reg(agfs_pkg::REG_RATE, 23'd0);
		write_reg(REG_UNUSED, 23'h5A5A5A);
		push_sample(sample_t'(24'h7FFFFF), 1'b0);
		push_sample(sample_t'(24'h800000), 1'b0);
		push_sample(sample_t'(4194304), 1'b1);
		push_sample(sample_t'(-4194304), 1'b0);
		push_sample(sample_t'(1), 1'b0);
		push_sample(sample_t'(-1), 1'b0);
		push_sample(sample_t'(0), 1'b0);
		push_sample(sample_t'(100000), 1'b1);
		wait_for_results(4);

		write_reg(agfs_pkg::REG_MAIN_GAIN, 23'd655);
		write_reg(agfs_pkg::REG_FADE, 23'd0);
		write_reg(agfs_pkg::REG_RATE, 23'h3FFFF);
		push_sample(sample_t'(24'h7FFFFF), 1'b0);
		push_sample(sample_t'(24'h800000), 1'b1);
		push_sample(sample_t'(24'h555555), 1'b0);
		push_sample(sample_t'(24'hAAAAAA), 1'b0);
		push_sample(sample_t'(-77), 1'b1);
		wait_for_results(4);
		phases = 3;

		while (samples_sent < SAMPLE_TARGET) begin
			retune();
			sender_calm = ($urandom_range(0, 3) == 0);
			sink_calm = ($urandom_range(0, 3) == 0);
			run_len = $urandom_range(20, 60);
			repeat (run_len)
				push_sample(random_sample(), $urandom_range(0, 7) == 0);
			wait_for_results(4);
			phases++;
		end

		wait_for_results(130);
		$display("Covered %0d samples over %0d register settings with %0d writes; %0d compared.",
			samples_sent, phases, reg_writes, sb.compared);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
